// ===== rtl/abz_pkg.sv =====
// ----------------------------------------------------------------------------
// abz_pkg: shared types and constants of the ABZ encoder angle and speed unit
// Op codes, register indexes, reset values, sequencer states and the command
// that the sequencer hands to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package abz_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 8;

	// input op codes
	localparam logic [2:0] OP_INDEX   = 3'd0;
	localparam logic [2:0] OP_ANGLE   = 3'd1;
	localparam logic [2:0] OP_M_SPEED = 3'd2;
	localparam logic [2:0] OP_T_SPEED = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SHIFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_M_SPEED_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_T_SPEED_SCALE  = 3'd4;

	// register reset values
	localparam logic [15:0] CPR_RST    = 16'd4096;
	localparam logic [5:0]  PP_RST     = 6'd7;
	localparam logic [15:0] PHASE_RST  = 16'd0;
	localparam logic [31:0] MSCALE_RST = 32'd65536;
	localparam logic [31:0] TSCALE_RST = 32'd65536;

	localparam logic [15:0] REV_MAX = 16'hFFFF;

	localparam logic [31:0] SPD_POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] SPD_NEG_LIMIT = 32'h8000_0000;

	typedef enum logic [0:0] {
		AM_DIV,
		AM_MUL
	} arith_mode_t;

	typedef struct packed {
		logic              start;
		arith_mode_t       mode;
		logic [STEP_W-1:0] steps;
	} arith_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIN,
		ST_DIV1,
		ST_DIV2,
		ST_MDELTA,
		ST_MABS,
		ST_SPD,
		ST_MUL
	} state_t;

endpackage

// ===== rtl/abz_encoder_angle_speed_unit.sv =====
// ----------------------------------------------------------------------------
// abz_encoder_angle_speed_unit: ABZ encoder angle and M/T speed unit
// Index, angle, M-method speed, T-method speed and clear beats, one result
// beat each; one shared iterative divide/multiply unit under a sequencer.
// ----------------------------------------------------------------------------
// Index, clear and spare ops go straight to the result stage; angle waits on the
// bit-serial divide, M and T speed on the 32-step multiply; zero or saturated
// speed and zero period finish early.
// One item at a time: the next beat is taken in the cycle after the result is
// registered. Reset clears state, registers to defaults, and the output beat.
// ----------------------------------------------------------------------------
module abz_encoder_angle_speed_unit #(
	parameter int COUNT_WIDTH = abz_pkg::COUNT_WIDTH_DEF,
	parameter int ANGLE_WIDTH = abz_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [abz_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [abz_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     op,
	input  logic [COUNT_WIDTH-1:0]         count,
	input  logic                           dir_down,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ANGLE_WIDTH-1:0]         mech_angle,
	output logic [ANGLE_WIDTH-1:0]         elec_angle,
	output logic signed [31:0]             speed_rpm,
	output logic                           reload_req,
	output logic [15:0]                    reload_value,
	output logic                           aligned
);

	localparam int CW   = COUNT_WIDTH;
	localparam int AW   = ANGLE_WIDTH;
	localparam int DIVW = CW + AW;
	localparam int SRW  = (DIVW > 32) ? DIVW : 32;
	localparam int DTW  = ((CW > 32) ? CW : 32) + 3;

	// configuration
	logic [15:0] cpr_q;
	logic [5:0]  pp_q;
	logic [15:0] phase_q;
	logic [31:0] mscale_q;
	logic [31:0] tscale_q;

	// block state
	abz_pkg::state_t state_q, state_d;
	logic            aligned_q;
	logic [15:0]     rev_q;
	logic [CW-1:0]   prev_q;
	logic            ldir_q;
	logic            out_valid_q;

	// work registers
	logic                  down_q;
	logic signed [DTW-1:0] base_q;
	logic [31:0]           wrap_q;
	logic signed [DTW-1:0] delta_q;
	logic [DTW-2:0]        mag_q;
	logic                  neg_q;
	logic [31:0]           scale_q;

	// result staging and output beat
	logic [AW-1:0] res_mech_q, res_elec_q;
	logic [31:0]   res_speed_q;
	logic          res_req_q;
	logic [15:0]   res_rval_q;
	logic [AW-1:0] out_mech_q, out_elec_q;
	logic [31:0]   out_speed_q;
	logic          out_req_q;
	logic [15:0]   out_rval_q;
	logic          out_aligned_q;

	// arithmetic unit
	abz_pkg::arith_cmd_t cmd;
	logic [31:0]         au_hi_init;
	logic [SRW-1:0]      au_sr_init;
	logic [31:0]         au_opnd;
	logic                au_busy;
	logic [31:0]         au_hi;
	logic [SRW-1:0]      au_sr;

	logic                  accept;
	logic                  fin_go;
	logic signed [DTW-1:0] c_ext, pv_ext, p_ext, base_d;
	logic [31:0]           wrap_d;
	logic [21:0]           pp_rem;
	logic [AW-1:0]         elec_d;
	logic                  spd_zero, spd_big;
	logic [31:0]           limit;
	logic [63:0]           prod;
	logic [31:0]           prod_sat;
	logic [31:0]           speed_d;
	logic signed [DTW-1:0] delta_abs;

	assign in_ready     = (state_q == abz_pkg::ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign fin_go       = (state_q == abz_pkg::ST_FIN) && (!out_valid_q || out_ready);

	assign out_valid    = out_valid_q;
	assign mech_angle   = out_mech_q;
	assign elec_angle   = out_elec_q;
	assign speed_rpm    = out_speed_q;
	assign reload_req   = out_req_q;
	assign reload_value = out_rval_q;
	assign aligned      = out_aligned_q;

	abz_arith #(
		.SR_WIDTH(SRW)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.hi_init(au_hi_init),
		.sr_init(au_sr_init),
		.opnd   (au_opnd),
		.busy   (au_busy),
		.hi     (au_hi),
		.sr     (au_sr)
	);

	// datapath terms
	always_comb begin
		c_ext  = $signed({{(DTW-CW){1'b0}}, count});
		pv_ext = $signed({{(DTW-CW){1'b0}}, prev_q});
		p_ext  = $signed({{(DTW-16){1'b0}}, cpr_q});
		// count change within the revolution, with the wrap term after a rollover
		if (!dir_down)
			base_d = (rev_q != '0) ? c_ext + (p_ext - pv_ext) : c_ext - pv_ext;
		else
			base_d = (rev_q != '0) ? pv_ext + (p_ext - c_ext) : pv_ext - c_ext;
		wrap_d = (rev_q > 16'd1) ? ({16'b0, rev_q - 16'd1} * {16'b0, cpr_q}) : 32'b0;

		pp_rem = {16'b0, pp_q} * {6'b0, au_hi[15:0]};
		elec_d = AW'({{AW{1'b0}}, pp_q} * {6'b0, res_mech_q})
			+ AW'(au_sr[5:0]) + AW'(phase_q);

		delta_abs = delta_q[DTW-1] ? -delta_q : delta_q;

		spd_zero = (mag_q == '0) || (scale_q == '0);
		spd_big  = (mag_q[DTW-2:32] != '0);
		limit    = neg_q ? abz_pkg::SPD_NEG_LIMIT : abz_pkg::SPD_POS_LIMIT;
		prod     = {au_hi, au_sr[31:0]};
		prod_sat = (prod > {32'b0, limit}) ? limit : prod[31:0];
		speed_d  = neg_q ? (32'd0 - prod_sat) : prod_sat;
	end

	// sequencer: next state and arithmetic commands
	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.mode   = abz_pkg::AM_DIV;
		cmd.steps  = '0;
		au_hi_init = '0;
		au_sr_init = '0;
		au_opnd    = '0;
		case (state_q)
			abz_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						abz_pkg::OP_ANGLE: begin
							if (cpr_q == '0) begin
								state_d = abz_pkg::ST_FIN;
							end else begin
								// count scaled by one turn, dividend enters at the top
								cmd.start  = 1'b1;
								cmd.mode   = abz_pkg::AM_DIV;
								cmd.steps  = abz_pkg::STEP_W'(DIVW);
								au_sr_init = {count, {(SRW-CW){1'b0}}};
								au_opnd    = {16'b0, cpr_q};
								state_d    = abz_pkg::ST_DIV1;
							end
						end
						abz_pkg::OP_M_SPEED: state_d = abz_pkg::ST_MDELTA;
						abz_pkg::OP_T_SPEED: state_d = abz_pkg::ST_SPD;
						default:             state_d = abz_pkg::ST_FIN;
					endcase
				end
			end
			abz_pkg::ST_DIV1: begin
				if (!au_busy) begin
					// fraction of pole count times remainder over period, below 64
					cmd.start  = 1'b1;
					cmd.mode   = abz_pkg::AM_DIV;
					cmd.steps  = abz_pkg::STEP_W'(6);
					au_hi_init = {16'b0, pp_rem[21:6]};
					au_sr_init = {pp_rem[5:0], {(SRW-6){1'b0}}};
					au_opnd    = {16'b0, cpr_q};
					state_d    = abz_pkg::ST_DIV2;
				end
			end
			abz_pkg::ST_DIV2: begin
				if (!au_busy)
					state_d = abz_pkg::ST_FIN;
			end
			abz_pkg::ST_MDELTA: state_d = abz_pkg::ST_MABS;
			abz_pkg::ST_MABS:   state_d = abz_pkg::ST_SPD;
			abz_pkg::ST_SPD: begin
				if (spd_zero || spd_big) begin
					state_d = abz_pkg::ST_FIN;
				end else begin
					cmd.start  = 1'b1;
					cmd.mode   = abz_pkg::AM_MUL;
					cmd.steps  = abz_pkg::STEP_W'(32);
					au_sr_init = SRW'(mag_q[31:0]);
					au_opnd    = scale_q;
					state_d    = abz_pkg::ST_MUL;
				end
			end
			abz_pkg::ST_MUL: begin
				if (!au_busy)
					state_d = abz_pkg::ST_FIN;
			end
			abz_pkg::ST_FIN: begin
				if (fin_go)
					state_d = abz_pkg::ST_IDLE;
			end
			default: state_d = abz_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abz_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, block state, output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q       <= abz_pkg::CPR_RST;
			pp_q        <= abz_pkg::PP_RST;
			phase_q     <= abz_pkg::PHASE_RST;
			mscale_q    <= abz_pkg::MSCALE_RST;
			tscale_q    <= abz_pkg::TSCALE_RST;
			aligned_q   <= 1'b0;
			rev_q       <= '0;
			prev_q      <= '0;
			ldir_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					abz_pkg::CFG_COUNTS_PER_REV: cpr_q    <= cfg_wdata[15:0];
					abz_pkg::CFG_POLE_PAIRS:     pp_q     <= cfg_wdata[5:0];
					abz_pkg::CFG_PHASE_SHIFT:    phase_q  <= cfg_wdata[15:0];
					abz_pkg::CFG_M_SPEED_SCALE:  mscale_q <= cfg_wdata;
					abz_pkg::CFG_T_SPEED_SCALE:  tscale_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				case (op)
					abz_pkg::OP_INDEX: begin
						// first index only aligns; later ones count revolutions
						if (!aligned_q)
							aligned_q <= 1'b1;
						else if (rev_q != abz_pkg::REV_MAX)
							rev_q <= rev_q + 16'd1;
					end
					abz_pkg::OP_ANGLE: ldir_q <= dir_down;
					abz_pkg::OP_M_SPEED: begin
						rev_q  <= '0;
						prev_q <= count;
					end
					abz_pkg::OP_T_SPEED: rev_q     <= '0;
					abz_pkg::OP_CLEAR:   aligned_q <= 1'b0;
					default: ;
				endcase
			end
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			abz_pkg::ST_IDLE: begin
				if (accept) begin
					res_mech_q  <= '0;
					res_elec_q  <= '0;
					res_speed_q <= '0;
					res_req_q   <= (op == abz_pkg::OP_INDEX);
					res_rval_q  <= (op != abz_pkg::OP_INDEX) ? 16'd0
						: (ldir_q ? 16'd0 : cpr_q);
					down_q      <= dir_down;
					base_q      <= base_d;
					wrap_q      <= wrap_d;
					case (op)
						abz_pkg::OP_M_SPEED: scale_q <= mscale_q;
						abz_pkg::OP_T_SPEED: begin
							scale_q <= tscale_q;
							mag_q   <= (DTW-1)'(rev_q);
							neg_q   <= 1'b0;
						end
						default: ;
					endcase
				end
			end
			abz_pkg::ST_DIV1: begin
				if (!au_busy)
					res_mech_q <= au_sr[AW-1:0];
			end
			abz_pkg::ST_DIV2: begin
				if (!au_busy)
					res_elec_q <= elec_d;
			end
			abz_pkg::ST_MDELTA: begin
				delta_q <= base_q + $signed({{(DTW-32){1'b0}}, wrap_q});
			end
			abz_pkg::ST_MABS: begin
				mag_q <= delta_abs[DTW-2:0];
				neg_q <= delta_q[DTW-1] ^ down_q;
			end
			abz_pkg::ST_SPD: begin
				if (spd_zero)
					res_speed_q <= '0;
				else if (spd_big)
					res_speed_q <= limit;
			end
			abz_pkg::ST_MUL: begin
				if (!au_busy)
					res_speed_q <= speed_d;
			end
			default: ;
		endcase
		if (fin_go) begin
			out_mech_q    <= res_mech_q;
			out_elec_q    <= res_elec_q;
			out_speed_q   <= res_speed_q;
			out_req_q     <= res_req_q;
			out_rval_q    <= res_rval_q;
			out_aligned_q <= aligned_q;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input beat taken while busy");

	a_index_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reload_req |-> (speed_rpm == 0) && (mech_angle == '0)
			&& (elec_angle == '0))
		else $error("index beat carries angle or speed");

	a_rev_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		rev_q == abz_pkg::REV_MAX |=> (rev_q == abz_pkg::REV_MAX) || (rev_q == '0))
		else $error("revolution count wrapped");

endmodule

// ===== rtl/abz_arith.sv =====
// ----------------------------------------------------------------------------
// abz_arith: shared iterative arithmetic unit
// One bit per cycle: restoring division by a 16-bit divisor, or shift-add
// multiplication of two 32-bit operands into a 64-bit product {hi, sr[31:0]}.
// ----------------------------------------------------------------------------
module abz_arith #(
	parameter int SR_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  abz_pkg::arith_cmd_t cmd,
	input  logic [31:0]         hi_init,
	input  logic [SR_WIDTH-1:0] sr_init,
	input  logic [31:0]         opnd,
	output logic                busy,
	output logic [31:0]         hi,
	output logic [SR_WIDTH-1:0] sr
);

	logic [abz_pkg::STEP_W-1:0] cnt_q;
	abz_pkg::arith_mode_t       mode_q;
	logic [31:0]                hi_q;
	logic [SR_WIDTH-1:0]        sr_q;
	logic [31:0]                opnd_q;

	logic [16:0]         trial;
	logic [33:0]         add_a;
	logic [33:0]         add_b;
	logic                add_c;
	logic [33:0]         sum;
	logic [31:0]         hi_n;
	logic [SR_WIDTH-1:0] sr_n;

	assign busy = (cnt_q != '0);
	assign hi   = hi_q;
	assign sr   = sr_q;

	// single adder shared by both modes
	always_comb begin
		trial = {hi_q[15:0], sr_q[SR_WIDTH-1]};
		case (mode_q)
			abz_pkg::AM_DIV: begin
				add_a = {17'b0, trial};
				add_b = ~{18'b0, opnd_q[15:0]};
				add_c = 1'b1;
			end
			abz_pkg::AM_MUL: begin
				add_a = {2'b0, hi_q};
				add_b = sr_q[0] ? {2'b0, opnd_q} : 34'b0;
				add_c = 1'b0;
			end
			default: begin
				add_a = '0;
				add_b = '0;
				add_c = 1'b0;
			end
		endcase
		sum = add_a + add_b + {33'b0, add_c};

		case (mode_q)
			abz_pkg::AM_DIV: begin
				// no borrow: take the difference and shift in a one
				hi_n = sum[33] ? {15'b0, trial} : {15'b0, sum[16:0]};
				sr_n = {sr_q[SR_WIDTH-2:0], ~sum[33]};
			end
			abz_pkg::AM_MUL: begin
				hi_n     = sum[32:1];
				sr_n     = sr_q >> 1;
				sr_n[31] = sum[0];
			end
			default: begin
				hi_n = hi_q;
				sr_n = sr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mode_q <= abz_pkg::AM_DIV;
		end else if (cmd.start) begin
			cnt_q  <= cmd.steps;
			mode_q <= cmd.mode;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hi_q   <= hi_init;
			sr_q   <= sr_init;
			opnd_q <= opnd;
		end else if (busy) begin
			hi_q <= hi_n;
			sr_q <= sr_n;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy)
		else $error("arith start while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && (cmd.steps != '0) |=> busy)
		else $error("arith not busy after start");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !cmd.start |=> (cnt_q + 1'b1) == $past(cnt_q))
		else $error("arith step count skipped");

endmodule

// ===== verif/tb_abz_encoder_angle_speed_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_abz_encoder_angle_speed_unit: self-checking bench of the ABZ encoder unit
// Drives index, angle, M speed, T speed, clear and spare events under random
// flow control, predicts every result beat in the bench and compares it field
// by field. Covers register extremes, zero period, speed saturation and a
// long output stall.
// ----------------------------------------------------------------------------
module tb_abz_encoder_angle_speed_unit;

	import abz_pkg::*;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_CODE_MAX    = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 50;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int PRINT_LIMIT    = 40;

	typedef struct packed {
		logic [15:0] mech_angle;
		logic [15:0] elec_angle;
		logic [31:0] speed_rpm;
		logic        reload_req;
		logic [15:0] reload_value;
		logic        aligned;
	} encoder_reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [2:0]            op;
	logic [15:0]           count;
	logic                  dir_down;
	logic                  out_valid;
	logic                  out_ready;
	logic [15:0]           mech_angle;
	logic [15:0]           elec_angle;
	logic signed [31:0]    speed_rpm;
	logic                  reload_req;
	logic [15:0]           reload_value;
	logic                  aligned;

	// shadow registers and encoder state of the predictor
	logic [15:0] cpr_set      = CPR_RST;
	logic [5:0]  pp_set       = PP_RST;
	logic [15:0] phase_set    = PHASE_RST;
	logic [31:0] mscale_set   = MSCALE_RST;
	logic [31:0] tscale_set   = TSCALE_RST;
	logic        aligned_seen = 1'b0;
	logic [15:0] revs_seen    = 16'd0;
	logic [15:0] last_capture = 16'd0;
	logic        last_down    = 1'b0;

	encoder_reading_t expected_readings[$];

	int mismatches      = 0;
	int hold_off_cycles = 0;
	bit src_idle_en     = 1'b1;
	bit sink_idle_en    = 1'b1;

	abz_encoder_angle_speed_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.count        (count),
		.dir_down     (dir_down),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mech_angle   (mech_angle),
		.elec_angle   (elec_angle),
		.speed_rpm    (speed_rpm),
		.reload_req   (reload_req),
		.reload_value (reload_value),
		.aligned      (aligned)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic logic [31:0] scaled_speed(input longint unsigned mag,
			input logic [31:0] scale, input logic neg);
		longint unsigned lim;
		longint unsigned prod;
		lim = neg ? {32'd0, SPD_NEG_LIMIT} : {32'd0, SPD_POS_LIMIT};
		if (mag == 0 || scale == 0)
			return 32'd0;
		if (mag > 64'hFFFF_FFFF) begin
			prod = lim;
		end else begin
			prod = mag * scale;
			if (prod > lim)
				prod = lim;
		end
		if (neg)
			prod = -prod;
		return prod[31:0];
	endfunction

	function automatic encoder_reading_t predict_encoder_reading(input logic [2:0] ev_op,
			input logic [15:0] ev_count, input logic ev_down);
		encoder_reading_t r;
		longint delta;
		longint prev_c;
		longint cnt_c;
		longint per;
		longint laps;
		longint unsigned scaled;
		longint unsigned mag;
		logic neg;
		r = '0;
		per = cpr_set;
		prev_c = last_capture;
		cnt_c = ev_count;
		case (ev_op)
			OP_INDEX: begin
				r.reload_req = 1'b1;
				r.reload_value = last_down ? 16'd0 : cpr_set;
				if (!aligned_seen)
					aligned_seen = 1'b1;
				else if (revs_seen != REV_MAX)
					revs_seen++;
			end
			OP_ANGLE: begin
				last_down = ev_down;
				if (cpr_set != 16'd0) begin
					scaled = {ev_count, 16'd0};
					r.mech_angle = 16'(scaled / cpr_set);
					r.elec_angle = 16'((scaled * pp_set) / cpr_set + phase_set);
				end
			end
			OP_M_SPEED: begin
				laps = revs_seen;
				revs_seen = 16'd0;
				if (!ev_down)
					delta = (laps > 0) ? cnt_c + (per - prev_c) : cnt_c - prev_c;
				else
					delta = (laps > 0) ? prev_c + (per - cnt_c) : prev_c - cnt_c;
				if (laps > 1)
					delta += (laps - 1) * per;
				last_capture = ev_count;
				neg = (delta < 0) != ev_down;
				mag = (delta < 0) ? -delta : delta;
				r.speed_rpm = scaled_speed(mag, mscale_set, neg);
			end
			OP_T_SPEED: begin
				r.speed_rpm = scaled_speed(revs_seen, tscale_set, 1'b0);
				revs_seen = 16'd0;
			end
			OP_CLEAR: begin
				aligned_seen = 1'b0;
			end
			default: ;
		endcase
		r.aligned = aligned_seen;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_readings.push_back(predict_encoder_reading(op, count, dir_down));
	end

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		encoder_reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected beat", speed_rpm, 32'd0);
			end else begin
				want = expected_readings.pop_front();
				if (mech_angle !== want.mech_angle)
					report_mismatch("mech_angle", mech_angle, want.mech_angle);
				if (elec_angle !== want.elec_angle)
					report_mismatch("elec_angle", elec_angle, want.elec_angle);
				if (speed_rpm !== want.speed_rpm)
					report_mismatch("speed_rpm", speed_rpm, want.speed_rpm);
				if (reload_req !== want.reload_req)
					report_mismatch("reload_req", reload_req, want.reload_req);
				if (reload_value !== want.reload_value)
					report_mismatch("reload_value", reload_value, want.reload_value);
				if (aligned !== want.aligned)
					report_mismatch("aligned", aligned, want.aligned);
			end
		end
	end

	// end the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// result sink: random stall bursts plus a requested long hold-off
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready = 1'b0;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send_event(input logic [2:0] ev_op, input logic [15:0] ev_count,
			input logic ev_down);
		int gap;
		gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		op = ev_op;
		count = ev_count;
		dir_down = ev_down;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid, then hold until every expected beat has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		case (idx)
			CFG_COUNTS_PER_REV: cpr_set = value[15:0];
			CFG_POLE_PAIRS:     pp_set = value[5:0];
			CFG_PHASE_SHIFT:    phase_set = value[15:0];
			CFG_M_SPEED_SCALE:  mscale_set = value;
			CFG_T_SPEED_SCALE:  tscale_set = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_settings(input logic [15:0] cpr, input logic [5:0] pp,
			input logic [15:0] phase_off, input logic [31:0] ms, input logic [31:0] ts);
		write_reg(CFG_COUNTS_PER_REV, {16'd0, cpr});
		write_reg(CFG_POLE_PAIRS, {26'd0, pp});
		write_reg(CFG_PHASE_SHIFT, {16'd0, phase_off});
		write_reg(CFG_M_SPEED_SCALE, ms);
		write_reg(CFG_T_SPEED_SCALE, ts);
	endtask

	// favor values at the edges of the field and of the period
	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return cpr_set - 16'd1;
			3: return cpr_set;
			4, 5: return 16'($urandom_range(0, cpr_set));
			default: return 16'($urandom);
		endcase
	endfunction

	// one direction, an angle to latch it, some index pulses, then a speed event
	task automatic send_revolution_run(output int n_sent);
		logic down;
		logic [2:0] speed_op;
		int laps;
		int i;
		down = 1'($urandom_range(0, 1));
		laps = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
		speed_op = ($urandom_range(0, 2) != 0) ? OP_M_SPEED : OP_T_SPEED;
		n_sent = 0;
		send_event(OP_ANGLE, pick_count(), down);
		n_sent++;
		for (i = 0; i < laps; i++) begin
			send_event(OP_INDEX, pick_count(), down);
			n_sent++;
			if ($urandom_range(0, 2) == 0) begin
				send_event(OP_ANGLE, pick_count(), down);
				n_sent++;
			end
		end
		send_event(speed_op, pick_count(), down);
		n_sent++;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_events();
		int i;
		// reset settings: period 4096, seven pole pairs, speed scales of 65536
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'hFFFF, 1'b1);
		send_event(OP_ANGLE, 16'd0, 1'b0);
		send_event(OP_ANGLE, 16'd4095, 1'b0);
		send_event(OP_ANGLE, 16'hFFFF, 1'b1);
		send_event(OP_INDEX, 16'd10, 1'b0);
		send_event(OP_M_SPEED, 16'd100, 1'b1);
		send_event(OP_ANGLE, 16'd2048, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_M_SPEED, 16'hFFFF, 1'b0);
		send_event(OP_M_SPEED, 16'd0, 1'b0);
		send_event(OP_M_SPEED, 16'd0, 1'b1);
		for (i = 0; i < 3; i++)
			send_event(OP_INDEX, 16'd1, 1'b0);
		send_event(OP_T_SPEED, 16'd0, 1'b0);
		send_event(OP_T_SPEED, 16'hFFFF, 1'b1);
		send_event(OP_CLEAR, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		for (i = OP_SPARE_FIRST; i <= OP_CODE_MAX; i++)
			send_event(i[2:0], (i[0] ? 16'hFFFF : 16'd0), i[1]);
		send_event(OP_CLEAR, 16'hFFFF, 1'b1);
	endtask

	task automatic test_register_extremes();
		wait_drained();
		// zero period: angles read zero, the wrap term adds nothing
		program_settings(16'd0, 6'd63, 16'hFFFF, 32'd1, 32'd0);
		send_event(OP_ANGLE, 16'd12345, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_M_SPEED, 16'd7, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_T_SPEED, 16'd0, 1'b0);
		wait_drained();
		write_reg(CFG_COUNTS_PER_REV, 32'd1);
		write_reg(CFG_POLE_PAIRS, 32'd0);
		send_event(OP_ANGLE, 16'd1, 1'b0);
		wait_drained();
		write_reg(CFG_POLE_PAIRS, 32'd32);
		send_event(OP_ANGLE, 16'd0, 1'b0);
		send_event(OP_ANGLE, 16'd1, 1'b1);
		send_event(OP_ANGLE, 16'hFFFF, 1'b0);
		wait_drained();
		// widest period and full-scale speed factors: hit both saturation limits
		program_settings(16'hFFFF, 6'd1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(OP_ANGLE, 16'hFFFE, 1'b0);
		send_event(OP_ANGLE, 16'hFFFF, 1'b0);
		send_event(OP_M_SPEED, 16'hFFFF, 1'b0);
		send_event(OP_M_SPEED, 16'd0, 1'b0);
		send_event(OP_M_SPEED, 16'hFFFF, 1'b1);
		send_event(OP_M_SPEED, 16'd0, 1'b1);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_INDEX, 16'd0, 1'b0);
		send_event(OP_T_SPEED, 16'd0, 1'b0);
		wait_drained();
		write_reg(CFG_M_SPEED_SCALE, 32'd0);
		send_event(OP_M_SPEED, 16'd5, 1'b0);
	endtask

	task automatic test_output_backpressure();
		logic [2:0] rand_op;
		int i;
		wait_drained();
		src_idle_en = 1'b0;
		@(posedge clk);
		hold_off_cycles = HOLD_OFF_LEN;
		for (i = 0; i < 12; i++) begin
			rand_op = 3'($urandom_range(OP_INDEX, OP_CODE_MAX));
			send_event(rand_op, pick_count(), 1'($urandom_range(0, 1)));
		end
		src_idle_en = 1'b1;
	endtask

	task automatic test_random_traffic(input int n_items, input int first_phase,
			input int n_phases);
		logic [2:0] rand_op;
		logic [15:0] cpr;
		logic [5:0] pp;
		logic [31:0] ms;
		logic [31:0] ts;
		int ph;
		int sent;
		int burst;
		for (ph = first_phase; ph < first_phase + n_phases; ph++) begin
			wait_drained();
			case (ph)
				0: program_settings(16'd1, 6'd32, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
				1: program_settings(16'hFFFF, 6'd1, 16'd0, 32'd1, 32'hFFFF_FFFF);
				default: begin
					cpr = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 16))
						: 16'($urandom_range(1, 65535));
					pp = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
						: 6'($urandom_range(1, 32));
					ms = $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000) : $urandom;
					ts = $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000) : $urandom;
					program_settings(cpr, pp, 16'($urandom), ms, ts);
				end
			endcase
			sent = 0;
			while (sent < n_items / n_phases) begin
				if ($urandom_range(0, 3) != 0) begin
					send_revolution_run(burst);
					sent += burst;
				end else begin
					rand_op = 3'($urandom_range(OP_INDEX, OP_CODE_MAX));
					send_event(rand_op, pick_count(), 1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin : run
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_COUNTS_PER_REV;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_INDEX;
		count = 16'd0;
		dir_down = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic(540, 0, 6);
		// last stretch runs at full rate on both sides
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		test_random_traffic(120, 6, 1);
		wait_drained();

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
